// ===== rtl/thpq_pkg.sv =====
// Shared types and constants for the ternary heap priority queue.
`timescale 1ns / 1ps
package thpq_pkg;
    localparam logic [0:0] REQ_INSERT = 1'b0;
    localparam logic [0:0] REQ_REMOVE = 1'b1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [0:0] CFG_HEAP_MODE = 1'b0;
    localparam logic [0:0] CFG_CAPACITY = 1'b1;
    localparam int CFG_INDEX_W = 1;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
endpackage

// ===== rtl/ternary_heap_priority_queue.sv =====
// Top level: ternary heap priority queue with sequencer around one key memory.
//
//  channel | signals                                  | direction
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in (ready out)
//  in      | in_valid in_stall req_type new_value     | in (stall out)
//  out     | out_valid out_stall removed_value status | out (stall in)
//          | top_value top_valid count_now            |
//
// One item at a time. Insert: accept step, then per level climbed a parent read
// and a compare-and-write step, one more step when the root is reached, then
// the output step. Remove: accept step, per level descended up to three child
// reads through the one read port and then a swap, a read and a swap at the
// last node, then the output step.
// The root is mirrored in a register so top_value needs no memory read.
// Reset clears the count and registers; memory contents need no reset.
// A result waits in the output register while out_stall is high; the next
// item is taken only after it leaves.
`timescale 1ns / 1ps
module ternary_heap_priority_queue #(
    parameter int HEAP_DEPTH = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [thpq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [thpq_pkg::COUNT_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [thpq_pkg::VALUE_W-1:0]  new_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [thpq_pkg::VALUE_W-1:0]  removed_value,
    output logic [1:0]                           status,
    output logic signed [thpq_pkg::VALUE_W-1:0]  top_value,
    output logic                                 top_valid,
    output logic [thpq_pkg::COUNT_W-1:0]         count_now
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = AW + 1;
    localparam int VW = thpq_pkg::VALUE_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);
    localparam logic [KEY_WIDTH-1:0] SIGN_C = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD0, S_DN_RD1, S_DN_RD2, S_DN_RD3,
        S_DN_SWAP, S_OUT
    } state_t;

    state_t state_reg;
    logic heap_mode_reg;
    logic [thpq_pkg::COUNT_W-1:0] cap_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg, best_reg;
    logic [KEY_WIDTH-1:0] cur_reg, best_key_reg, root_reg;
    logic [1:0] nchild_reg;
    logic [AW-1:0] caddr_reg;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [KEY_WIDTH-1:0] wr_data, rd_data;

    thpq_mem #(.DEPTH(HEAP_DEPTH), .WIDTH(KEY_WIDTH), .AW(AW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    function automatic logic above(input logic m, input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
        above = m ? (a < b) : (a > b);
    endfunction

    function automatic logic [VW-1:0] key_out(input logic [KEY_WIDTH-1:0] k);
        logic [KEY_WIDTH-1:0] v;
        v = k ^ SIGN_C;
        key_out = VW'($signed(v));
    endfunction

    logic [KEY_WIDTH-1:0] key_in;
    logic [CW-1:0] cap_eff;
    logic [AW+1:0] first_w;
    logic [AW+1:0] rem_w;
    logic [AW-1:0] parent;
    logic [AW-1:0] pos_m1;
    logic [33:0] parent_prod;

    assign key_in = KEY_WIDTH'($signed(new_value)) ^ SIGN_C;
    assign cap_eff = ({1'b0, cap_reg} > (thpq_pkg::COUNT_W+1)'(DEPTH_C)) ? DEPTH_C
                     : CW'(cap_reg);
    assign first_w = (AW+2)'(pos_reg) * (AW+2)'(3) + (AW+2)'(1);
    assign rem_w = (AW+2)'(count_reg) - first_w;
    // (pos - 1) / 3 by reciprocal multiply, exact up to 16 address bits
    assign pos_m1 = pos_reg - AW'(1);
    assign parent_prod = 34'(pos_m1) * 34'd43691;
    assign parent = AW'(parent_prod >> 17);

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        rd_addr = parent;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && req_type == thpq_pkg::REQ_INSERT
                    && count_reg < cap_eff)
                begin
                    wr_en = 1'b1;
                    wr_addr = AW'(count_reg);
                    wr_data = key_in;
                end
                rd_addr = AW'(count_reg - CW'(1));
            end
            S_UP_CMP:
            begin
                if (above(heap_mode_reg, cur_reg, rd_data))
                begin
                    wr_en = 1'b1;
                    wr_data = rd_data;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            S_DN_RD0: rd_addr = AW'(first_w);
            S_DN_RD1: rd_addr = caddr_reg;
            S_DN_RD2: rd_addr = caddr_reg;
            S_DN_SWAP:
            begin
                wr_en = 1'b1;
                if (above(heap_mode_reg, best_key_reg, cur_reg))
                begin
                    wr_data = best_key_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            heap_mode_reg <= 1'b0;
            cap_reg <= thpq_pkg::COUNT_W'(1024);
            count_reg <= '0;
            out_valid <= 1'b0;
            pos_reg <= '0;
            best_reg <= '0;
            cur_reg <= '0;
            best_key_reg <= '0;
            root_reg <= '0;
            nchild_reg <= '0;
            caddr_reg <= '0;
            removed_value <= '0;
            status <= thpq_pkg::ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == thpq_pkg::CFG_HEAP_MODE)
                            heap_mode_reg <= cfg_data[0];
                        else if (cfg_index == thpq_pkg::CFG_CAPACITY)
                            cap_reg <= cfg_data;
                    end
                    if (in_valid)
                    begin
                        removed_value <= '0;
                        status <= thpq_pkg::ST_OK;
                        if (req_type == thpq_pkg::REQ_INSERT)
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                status <= thpq_pkg::ST_FULL;
                                state_reg <= S_OUT;
                                out_valid <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + CW'(1);
                                pos_reg <= AW'(count_reg);
                                cur_reg <= key_in;
                                if (count_reg == '0)
                                begin
                                    root_reg <= key_in;
                                    state_reg <= S_OUT;
                                    out_valid <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_UP_RD;
                                end
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                status <= thpq_pkg::ST_EMPTY;
                                state_reg <= S_OUT;
                                out_valid <= 1'b1;
                            end
                            else
                            begin
                                removed_value <= key_out(root_reg);
                                count_reg <= count_reg - CW'(1);
                                pos_reg <= '0;
                                state_reg <= (count_reg == CW'(1)) ? S_OUT : S_DN_RD0;
                                out_valid <= (count_reg == CW'(1));
                            end
                        end
                    end
                end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (above(heap_mode_reg, cur_reg, rd_data))
                    begin
                        pos_reg <= parent;
                        if (parent == '0)
                        begin
                            root_reg <= cur_reg;
                            state_reg <= S_DN_SWAP;
                            best_key_reg <= cur_reg;
                            cur_reg <= cur_reg;
                        end
                        else
                        begin
                            state_reg <= S_UP_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        out_valid <= 1'b1;
                    end
                end
                S_DN_RD0:
                begin
                    // last element (read issued in idle) becomes the root candidate
                    if (first_w >= (AW+2)'(count_reg))
                    begin
                        if (pos_reg == '0)
                        begin
                            cur_reg <= rd_data;
                            root_reg <= rd_data;
                        end
                        state_reg <= S_DN_SWAP;
                        best_key_reg <= (pos_reg == '0) ? rd_data : cur_reg;
                        best_reg <= pos_reg;
                    end
                    else
                    begin
                        if (pos_reg == '0)
                            cur_reg <= rd_data;
                        nchild_reg <= (rem_w >= (AW+2)'(3)) ? 2'd3 : 2'(rem_w);
                        caddr_reg <= AW'(first_w + (AW+2)'(1));
                        best_reg <= AW'(first_w);
                        state_reg <= S_DN_RD1;
                    end
                end
                S_DN_RD1:
                begin
                    best_key_reg <= rd_data;
                    if (nchild_reg >= 2'd2)
                    begin
                        caddr_reg <= caddr_reg + AW'(1);
                        state_reg <= S_DN_RD2;
                    end
                    else
                    begin
                        state_reg <= S_DN_SWAP;
                    end
                end
                S_DN_RD2:
                begin
                    if (above(heap_mode_reg, rd_data, best_key_reg))
                    begin
                        best_key_reg <= rd_data;
                        best_reg <= caddr_reg - AW'(1);
                    end
                    state_reg <= (nchild_reg == 2'd3) ? S_DN_RD3 : S_DN_SWAP;
                end
                S_DN_RD3:
                begin
                    if (above(heap_mode_reg, rd_data, best_key_reg))
                    begin
                        best_key_reg <= rd_data;
                        best_reg <= caddr_reg;
                    end
                    state_reg <= S_DN_SWAP;
                end
                S_DN_SWAP:
                begin
                    if (above(heap_mode_reg, best_key_reg, cur_reg))
                    begin
                        if (pos_reg == '0)
                            root_reg <= best_key_reg;
                        pos_reg <= best_reg;
                        state_reg <= S_DN_RD0;
                    end
                    else
                    begin
                        if (pos_reg == '0)
                            root_reg <= cur_reg;
                        state_reg <= S_OUT;
                        out_valid <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign top_valid = (count_reg != '0);
    assign top_value = top_valid ? $signed(key_out(root_reg)) : '0;
    assign count_now = thpq_pkg::COUNT_W'(count_reg);
endmodule

// ===== rtl/thpq_mem.sv =====
// Single-port-write, single-port-read key store with registered read data.
`timescale 1ns / 1ps
module thpq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== tb/heap_checker.sv =====
// Checker for the ternary heap queue: models the heap, compares each result.
`timescale 1ns / 1ps
module heap_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [thpq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [thpq_pkg::COUNT_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [thpq_pkg::VALUE_W-1:0]  new_value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [thpq_pkg::VALUE_W-1:0]  removed_value,
    input  logic [1:0]                           status,
    input  logic signed [thpq_pkg::VALUE_W-1:0]  top_value,
    input  logic                                 top_valid,
    input  logic [thpq_pkg::COUNT_W-1:0]         count_now,
    output int                                   fail_count,
    output int                                   pending
);
    localparam int DEPTH = 1024;

    typedef struct packed {
        logic signed [thpq_pkg::VALUE_W-1:0] removed;
        logic [1:0]                          st;
        logic signed [thpq_pkg::VALUE_W-1:0] top;
        logic                                top_ok;
        logic [thpq_pkg::COUNT_W-1:0]        cnt;
    } heap_result_t;

    logic signed [thpq_pkg::VALUE_W-1:0] keys [DEPTH];
    int                                  key_count;
    logic                                min_order;
    int                                  cap_limit;
    heap_result_t                        expected_q[$];

    function automatic bit ranks_above(logic signed [thpq_pkg::VALUE_W-1:0] a,
                                       logic signed [thpq_pkg::VALUE_W-1:0] b);
        return min_order ? (a < b) : (a > b);
    endfunction

    task automatic apply_request(logic rt, logic signed [thpq_pkg::VALUE_W-1:0] key);
        heap_result_t r;
        int pos;
        int par;
        int first;
        int best;
        logic signed [thpq_pkg::VALUE_W-1:0] tmp;
        r = '0;
        if (rt == thpq_pkg::REQ_INSERT) begin
            if (key_count >= cap_limit) begin
                r.st = thpq_pkg::ST_FULL;
            end
            else begin
                keys[key_count] = key;
                pos = key_count;
                key_count++;
                while (pos >= 1) begin
                    par = (pos - 1) / 3;
                    if (!ranks_above(keys[pos], keys[par]))
                        break;
                    tmp = keys[pos]; keys[pos] = keys[par]; keys[par] = tmp;
                    pos = par;
                end
            end
        end
        else if (key_count == 0) begin
            r.st = thpq_pkg::ST_EMPTY;
        end
        else begin
            r.removed = keys[0];
            key_count--;
            keys[0] = keys[key_count];
            pos = 0;
            forever begin
                first = 3 * pos + 1;
                if (first >= key_count)
                    break;
                best = first;
                for (int c = first + 1; c < first + 3 && c < key_count; c++)
                    if (ranks_above(keys[c], keys[best]))
                        best = c;
                if (!ranks_above(keys[best], keys[pos]))
                    break;
                tmp = keys[pos]; keys[pos] = keys[best]; keys[best] = tmp;
                pos = best;
            end
        end
        r.top = key_count != 0 ? keys[0] : '0;
        r.top_ok = key_count != 0;
        r.cnt = thpq_pkg::COUNT_W'(key_count);
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t e;
        if (!rst_n) begin
            key_count = 0;
            min_order = 1'b0;
            cap_limit = DEPTH;
            fail_count = 0;
            expected_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == thpq_pkg::CFG_HEAP_MODE)
                    min_order = cfg_data[0];
                else if (cfg_index == thpq_pkg::CFG_CAPACITY)
                    cap_limit = (cfg_data > DEPTH) ? DEPTH : int'(cfg_data);
            end
            if (in_valid && !in_stall)
                apply_request(req_type, new_value);
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction at %0t", $time);
                end
                else begin
                    e = expected_q.pop_front();
                    if (e.removed !== removed_value || e.st !== status ||
                        e.top !== top_value || e.top_ok !== top_valid ||
                        e.cnt !== count_now) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch at %0t: exp rm=%0d st=%0d top=%0d",
                                      " tv=%0d cnt=%0d, got rm=%0d st=%0d top=%0d",
                                      " tv=%0d cnt=%0d"},
                                     $time, e.removed, e.st, e.top, e.top_ok, e.cnt,
                                     removed_value, status, top_value, top_valid,
                                     count_now);
                    end
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

// ===== tb/tb.sv =====
// Testbench top: stimulus, configuration phases and the verdict.
`timescale 1ns / 1ps
module tb;
    localparam int IDLE_LIMIT = 20000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [thpq_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [thpq_pkg::COUNT_W-1:0]        cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                req_type = thpq_pkg::REQ_INSERT;
    logic signed [thpq_pkg::VALUE_W-1:0] new_value = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [thpq_pkg::VALUE_W-1:0] removed_value;
    logic [1:0]                          status;
    logic signed [thpq_pkg::VALUE_W-1:0] top_value;
    logic                                top_valid;
    logic [thpq_pkg::COUNT_W-1:0]        count_now;
    int                                  fail_count;
    int                                  pending;
    int                                  send_idle_pct = 0;
    int                                  recv_stall_pct = 0;
    int                                  quiet_cycles = 0;

    always #2 clk = ~clk;

    ternary_heap_priority_queue dut (.*);

    heap_checker checker_i (.*);

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(logic rt, logic signed [thpq_pkg::VALUE_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        req_type <= rt;
        new_value <= key;
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [thpq_pkg::CFG_INDEX_W-1:0] idx,
                             logic [thpq_pkg::COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [thpq_pkg::VALUE_W-1:0] random_key();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(thpq_pkg::VALUE_W'($urandom_range(7))) - 3;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic random_burst(int n, int ins_pct);
        for (int i = 0; i < n; i++)
            send_request(($urandom_range(99) < ins_pct) ? thpq_pkg::REQ_INSERT
                                                        : thpq_pkg::REQ_REMOVE,
                         random_key());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, extremes, ties, full at capacity 2
        send_request(thpq_pkg::REQ_REMOVE, 32'sd5);
        send_request(thpq_pkg::REQ_INSERT, 32'sh7fffffff);
        send_request(thpq_pkg::REQ_INSERT, 32'sh80000000);
        send_request(thpq_pkg::REQ_INSERT, 32'sd0);
        send_request(thpq_pkg::REQ_INSERT, -32'sd1);
        send_request(thpq_pkg::REQ_INSERT, 32'sd0);
        for (int i = 0; i < 6; i++)
            send_request(thpq_pkg::REQ_REMOVE, 32'sh5555aaaa);
        drain_results();
        write_reg(thpq_pkg::CFG_CAPACITY, 11'd2);
        write_reg(thpq_pkg::CFG_HEAP_MODE, thpq_pkg::COUNT_W'(1));
        send_request(thpq_pkg::REQ_INSERT, 32'sd7);
        send_request(thpq_pkg::REQ_INSERT, -32'sd7);
        send_request(thpq_pkg::REQ_INSERT, 32'sd1);
        drain_results();
        write_reg(thpq_pkg::CFG_HEAP_MODE, thpq_pkg::COUNT_W'(0));
        send_request(thpq_pkg::REQ_REMOVE, 32'sd0);
        send_request(thpq_pkg::REQ_REMOVE, 32'sd0);
        drain_results();
        write_reg(thpq_pkg::CFG_CAPACITY, 11'd0);
        send_request(thpq_pkg::REQ_INSERT, 32'sd3);
        drain_results();
        write_reg(thpq_pkg::CFG_CAPACITY, 11'h7ff);
        send_request(thpq_pkg::REQ_INSERT, 32'sd3);
        send_request(thpq_pkg::REQ_REMOVE, 32'sd0);

        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            write_reg(thpq_pkg::CFG_HEAP_MODE, thpq_pkg::COUNT_W'(ph[0]));
            case (ph % 4)
                0: write_reg(thpq_pkg::CFG_CAPACITY, 11'd1);
                1: write_reg(thpq_pkg::CFG_CAPACITY, 11'd1024);
                2: write_reg(thpq_pkg::CFG_CAPACITY,
                             thpq_pkg::COUNT_W'($urandom_range(2, 40)));
                default: write_reg(thpq_pkg::CFG_CAPACITY, 11'd1100);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 5) begin
                // heap mode rewritten with keys held; the write repeats this phase's mode
                random_burst(120, 80);
                drain_results();
                write_reg(thpq_pkg::CFG_HEAP_MODE, thpq_pkg::COUNT_W'(1));
                random_burst(100, 50);
            end
            else if (ph == 1) begin
                random_burst(220, 100);
                random_burst(50, 90);
                random_burst(80, 15);
            end
            else begin
                random_burst(110, 65);
                random_burst(30, 40);
                drain_results();
                random_burst(70, 35);
            end
        end

        recv_stall_pct = 0;
        drain_results();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== ternary_heap_priority_queue.f =====
rtl/thpq_pkg.sv
rtl/thpq_mem.sv
rtl/ternary_heap_priority_queue.sv
tb/heap_checker.sv
tb/tb.sv
